// ===== hw/rtl/fat_cluster_chain_engine_defines.svh =====
// Assertion macros used by the RTL of the cluster chain engine.
`ifndef FAT_CLUSTER_CHAIN_ENGINE_DEFINES_SVH
`define FAT_CLUSTER_CHAIN_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/fcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fcc_pkg;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_READ   = 2'd1,
      OP_ALLOC  = 2'd2,
      OP_LOCATE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_UNMOUNTED = 2'd2,
      STAT_RANGE     = 2'd3
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_RDATA = 7'b0000010,
      ST_SCAN  = 7'b0000100,
      ST_WALK  = 7'b0001000,
      ST_NEXT  = 7'b0010000,
      ST_LINK  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      MODE_ALLOC  = 2'd0,
      MODE_FIRST  = 2'd1,
      MODE_EXTEND = 2'd2
   } scan_mode_type;

   localparam logic [1:0] CSR_ENTRY_COUNT  = 2'd0;
   localparam logic [1:0] CSR_CLUSTER_LOG2 = 2'd1;
   localparam logic [1:0] CSR_MOUNTED      = 2'd2;

   localparam logic [27:0] END_MARK  = 28'hFFFFFFF;
   localparam logic [27:0] END_LOW   = 28'hFFFFFF8;
   localparam logic [3:0]  SHIFT_MIN = 4'd9;
   localparam logic [3:0]  SHIFT_MAX = 4'd12;

endpackage

`default_nettype wire

// ===== hw/rtl/fat_cluster_chain_engine.sv =====
// The engine keeps a cluster allocation table of TABLE_DEPTH 28-bit entries in a single
// memory with one write and one read port and a registered read, and answers one
// request beat with one response beat. A load writes its entry directly; a read issues
// the table read and captures the data in ST_RDATA; either result then passes through
// ST_DONE into the output register. An allocate runs a first-fit scan that examines
// entries upward from entry 2 and is bounded by the entry count and the table depth.
// A locate reads one table entry per chain link walked, issuing the read in ST_WALK
// and consuming it in ST_NEXT, plus a scan (resuming after the previous find) for
// the first cluster when the file has none and for every end marker that has to be
// extended. The table is not cleared after reset: entries must be loaded before
// they are read, walked or scanned. A new request beat is taken as soon as the
// previous result sits in the output register, even while that beat is stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "fat_cluster_chain_engine_defines.svh"

module fat_cluster_chain_engine #(
   parameter int TABLE_DEPTH = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [15:0] req_entry_index,
   input  wire logic [27:0] req_entry_value,
   input  wire logic [15:0] req_start_cluster,
   input  wire logic [31:0] req_byte_position,
   input  wire logic [31:0] req_bytes_left,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [27:0]      rsp_value,
   output logic [15:0]      rsp_first_cluster,
   output logic [11:0]      rsp_offset,
   output logic [12:0]      rsp_chunk_length,
   output logic [1:0]       rsp_status,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [16:0] csr_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int SW = (AW + 1 > 17) ? AW + 1 : 17;
   localparam logic [27:0]   DEPTH_E = 28'(TABLE_DEPTH);
   localparam logic [SW-1:0] DEPTH_S = SW'(TABLE_DEPTH);

   logic [16:0] entry_count_ff;
   logic [3:0]  cluster_log2_ff;
   logic        mounted_ff;

   fcc_pkg::state_type     state_ff, state_in;
   fcc_pkg::scan_mode_type mode_ff, mode_in;
   logic [15:0]   start_ff, start_in;
   logic [27:0]   cur_ff, cur_in;
   logic [22:0]   steps_ff, steps_in;
   logic [11:0]   off_ff, off_in;
   logic [12:0]   len_ff, len_in;
   logic [SW-1:0] hint_ff, hint_in;
   logic [SW-1:0] scan_addr_ff, scan_addr_in;
   logic [SW-1:0] scan_chk_ff, scan_chk_in;
   logic          scan_vld_ff, scan_vld_in;

   logic [27:0] res_value_ff, res_value_in;
   logic [15:0] res_first_ff, res_first_in;
   logic [11:0] res_off_ff, res_off_in;
   logic [12:0] res_len_ff, res_len_in;
   fcc_pkg::status_type res_status_ff, res_status_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [27:0] rsp_value_ff, rsp_value_in;
   logic [15:0] rsp_first_ff, rsp_first_in;
   logic [11:0] rsp_off_ff, rsp_off_in;
   logic [12:0] rsp_len_ff, rsp_len_in;
   fcc_pkg::status_type rsp_status_ff, rsp_status_in;

   logic [27:0] fat_mem [TABLE_DEPTH];
   logic [27:0] rd_data_ff;
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [27:0]   wr_data;

   logic [3:0]    shift;
   logic [12:0]   csize;
   logic [11:0]   pos_off;
   logic [12:0]   room;
   logic [12:0]   chunk;
   logic [22:0]   pos_steps;
   logic [SW-1:0] count_ext;
   logic [SW-1:0] scan_lim;
   logic          found;
   logic [27:0]   idx_ext;

   assign req_stall         = reset || (state_ff != fcc_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_first_cluster = rsp_first_ff;
   assign rsp_offset        = rsp_off_ff;
   assign rsp_chunk_length  = rsp_len_ff;
   assign rsp_status        = rsp_status_ff;
   assign csr_ready         = !reset;

   always_comb begin
      if (cluster_log2_ff < fcc_pkg::SHIFT_MIN) begin
         shift = fcc_pkg::SHIFT_MIN;
      end else if (cluster_log2_ff > fcc_pkg::SHIFT_MAX) begin
         shift = fcc_pkg::SHIFT_MAX;
      end else begin
         shift = cluster_log2_ff;
      end
      csize     = 13'd1 << shift;
      pos_off   = req_byte_position[11:0] & 12'(csize - 13'd1);
      room      = csize - {1'b0, pos_off};
      chunk     = ({19'd0, room} > req_bytes_left) ? req_bytes_left[12:0] : room;
      pos_steps = 23'(req_byte_position >> shift);
      count_ext = SW'(entry_count_ff);
      scan_lim  = (count_ext > DEPTH_S) ? DEPTH_S : count_ext;
      found     = scan_vld_ff && (rd_data_ff == 28'd0);
      idx_ext   = 28'(req_entry_index);
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      start_in      = start_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      off_in        = off_ff;
      len_in        = len_ff;
      hint_in       = hint_ff;
      scan_addr_in  = scan_addr_ff;
      scan_chk_in   = scan_chk_ff;
      scan_vld_in   = scan_vld_ff;
      res_value_in  = res_value_ff;
      res_first_in  = res_first_ff;
      res_off_in    = res_off_ff;
      res_len_in    = res_len_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      case (state_ff)
         fcc_pkg::ST_IDLE: begin
            if (req_valid && !req_stall) begin
               start_in      = req_start_cluster;
               off_in        = pos_off;
               len_in        = chunk;
               steps_in      = pos_steps;
               hint_in       = SW'(2);
               scan_addr_in  = SW'(2);
               scan_vld_in   = 1'b0;
               res_value_in  = '0;
               res_first_in  = '0;
               res_off_in    = '0;
               res_len_in    = '0;
               res_status_in = fcc_pkg::STAT_OK;
               case (fcc_pkg::op_type'(req_op))
                  fcc_pkg::OP_LOAD, fcc_pkg::OP_READ: begin
                     if (idx_ext >= DEPTH_E) begin
                        res_status_in = fcc_pkg::STAT_RANGE;
                        state_in      = fcc_pkg::ST_DONE;
                     end else if (fcc_pkg::op_type'(req_op) == fcc_pkg::OP_LOAD) begin
                        wr_en        = 1'b1;
                        wr_addr      = idx_ext[AW-1:0];
                        wr_data      = req_entry_value;
                        res_value_in = req_entry_value;
                        state_in     = fcc_pkg::ST_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_ext[AW-1:0];
                        state_in = fcc_pkg::ST_RDATA;
                     end
                  end
                  fcc_pkg::OP_ALLOC: begin
                     if (!mounted_ff) begin
                        res_status_in = fcc_pkg::STAT_UNMOUNTED;
                        state_in      = fcc_pkg::ST_DONE;
                     end else begin
                        mode_in  = fcc_pkg::MODE_ALLOC;
                        state_in = fcc_pkg::ST_SCAN;
                     end
                  end
                  fcc_pkg::OP_LOCATE: begin
                     if (!mounted_ff) begin
                        res_status_in = fcc_pkg::STAT_UNMOUNTED;
                        state_in      = fcc_pkg::ST_DONE;
                     end else if (req_bytes_left == 32'd0) begin
                        res_first_in = req_start_cluster;
                        state_in     = fcc_pkg::ST_DONE;
                     end else if (req_start_cluster < 16'd2) begin
                        mode_in  = fcc_pkg::MODE_FIRST;
                        state_in = fcc_pkg::ST_SCAN;
                     end else begin
                        cur_in   = 28'(req_start_cluster);
                        state_in = fcc_pkg::ST_WALK;
                     end
                  end
                  default: begin
                     state_in = fcc_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         fcc_pkg::ST_RDATA: begin
            res_value_in = rd_data_ff;
            state_in     = fcc_pkg::ST_DONE;
         end

         fcc_pkg::ST_SCAN: begin
            if (found) begin
               wr_en   = 1'b1;
               wr_addr = scan_chk_ff[AW-1:0];
               wr_data = fcc_pkg::END_MARK;
               hint_in = scan_chk_ff + SW'(1);
               case (mode_ff)
                  fcc_pkg::MODE_ALLOC: begin
                     res_value_in = 28'(scan_chk_ff);
                     state_in     = fcc_pkg::ST_DONE;
                  end
                  fcc_pkg::MODE_FIRST: begin
                     start_in = scan_chk_ff[15:0];
                     cur_in   = 28'(scan_chk_ff);
                     state_in = fcc_pkg::ST_WALK;
                  end
                  fcc_pkg::MODE_EXTEND: begin
                     state_in = fcc_pkg::ST_LINK;
                  end
                  default: begin
                     state_in = fcc_pkg::ST_DONE;
                  end
               endcase
            end else if (scan_addr_ff < scan_lim) begin
               rd_en        = 1'b1;
               rd_addr      = scan_addr_ff[AW-1:0];
               scan_chk_in  = scan_addr_ff;
               scan_vld_in  = 1'b1;
               scan_addr_in = scan_addr_ff + SW'(1);
            end else begin
               res_status_in = fcc_pkg::STAT_FULL;
               res_first_in  = (mode_ff == fcc_pkg::MODE_EXTEND) ? start_ff : 16'd0;
               state_in      = fcc_pkg::ST_DONE;
            end
         end

         fcc_pkg::ST_WALK: begin
            if (steps_ff == 23'd0) begin
               res_value_in = cur_ff;
               res_first_in = start_ff;
               res_off_in   = off_ff;
               res_len_in   = len_ff;
               state_in     = fcc_pkg::ST_DONE;
            end else if (cur_ff >= DEPTH_E) begin
               res_status_in = fcc_pkg::STAT_RANGE;
               res_first_in  = start_ff;
               state_in      = fcc_pkg::ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = cur_ff[AW-1:0];
               state_in = fcc_pkg::ST_NEXT;
            end
         end

         fcc_pkg::ST_NEXT: begin
            if (rd_data_ff >= fcc_pkg::END_LOW) begin
               mode_in      = fcc_pkg::MODE_EXTEND;
               scan_addr_in = hint_ff;
               scan_vld_in  = 1'b0;
               state_in     = fcc_pkg::ST_SCAN;
            end else begin
               cur_in   = rd_data_ff;
               steps_in = steps_ff - 23'd1;
               state_in = fcc_pkg::ST_WALK;
            end
         end

         fcc_pkg::ST_LINK: begin
            wr_en    = 1'b1;
            wr_addr  = cur_ff[AW-1:0];
            wr_data  = 28'(scan_chk_ff);
            cur_in   = 28'(scan_chk_ff);
            steps_in = steps_ff - 23'd1;
            state_in = fcc_pkg::ST_WALK;
         end

         fcc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_first_in  = res_first_ff;
               rsp_off_in    = res_off_ff;
               rsp_len_in    = res_len_ff;
               rsp_status_in = res_status_ff;
               state_in      = fcc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = fcc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fat_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= fat_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= fcc_pkg::ST_IDLE;
         scan_vld_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         entry_count_ff  <= 17'd0;
         cluster_log2_ff <= fcc_pkg::SHIFT_MAX;
         mounted_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_vld_ff  <= scan_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fcc_pkg::CSR_ENTRY_COUNT: begin
                  entry_count_ff <= csr_data;
               end
               fcc_pkg::CSR_CLUSTER_LOG2: begin
                  cluster_log2_ff <= csr_data[3:0];
               end
               fcc_pkg::CSR_MOUNTED: begin
                  mounted_ff <= csr_data[0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      start_ff      <= start_in;
      cur_ff        <= cur_in;
      steps_ff      <= steps_in;
      off_ff        <= off_in;
      len_ff        <= len_in;
      hint_ff       <= hint_in;
      scan_addr_ff  <= scan_addr_in;
      scan_chk_ff   <= scan_chk_in;
      res_value_ff  <= res_value_in;
      res_first_ff  <= res_first_in;
      res_off_ff    <= res_off_in;
      res_len_ff    <= res_len_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_status_ff <= rsp_status_in;
   end

   `FCC_ASSERT_NOW(a_no_same_entry_clash, clock, reset, wr_en && rd_en, wr_addr != rd_addr, "table read and write hit the same entry in one cycle")
   `FCC_ASSERT_NEXT(a_done_delivers, clock, reset, (state_ff == fcc_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall), rsp_valid_ff && (state_ff == fcc_pkg::ST_IDLE), "finished result not moved into the output register")
   `FCC_ASSERT_NOW(a_next_follows_walk, clock, reset, state_ff == fcc_pkg::ST_NEXT, $past(state_ff) == fcc_pkg::ST_WALK, "chain link consumed without a read issued by the walk")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int TABLE_DEPTH = 65536;
   localparam int PREFIX = 96;
   localparam int WORK_BUDGET = 300;
   localparam int CYCLE_LIMIT = 10000000;

   typedef struct {
      fcc_pkg::op_type op;
      logic [15:0]     entry_index;
      logic [27:0]     entry_value;
      logic [15:0]     start_cluster;
      logic [31:0]     byte_position;
      logic [31:0]     bytes_left;
   } fat_request_type;

   typedef struct {
      logic [27:0]         value;
      logic [15:0]         first_cluster;
      logic [11:0]         offset;
      logic [12:0]         chunk_length;
      fcc_pkg::status_type status;
   } fat_answer_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = 2'd0;
   logic [15:0] req_entry_index = 16'd0;
   logic [27:0] req_entry_value = 28'd0;
   logic [15:0] req_start_cluster = 16'd0;
   logic [31:0] req_byte_position = 32'd0;
   logic [31:0] req_bytes_left = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [27:0] rsp_value;
   logic [15:0] rsp_first_cluster;
   logic [11:0] rsp_offset;
   logic [12:0] rsp_chunk_length;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = fcc_pkg::CSR_ENTRY_COUNT;
   logic [16:0] csr_data = 17'd0;

   fat_cluster_chain_engine #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_entry_index(req_entry_index),
      .req_entry_value(req_entry_value),
      .req_start_cluster(req_start_cluster),
      .req_byte_position(req_byte_position),
      .req_bytes_left(req_bytes_left),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_value(rsp_value),
      .rsp_first_cluster(rsp_first_cluster),
      .rsp_offset(rsp_offset),
      .rsp_chunk_length(rsp_chunk_length),
      .rsp_status(rsp_status),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   logic [27:0]  fat_shadow [TABLE_DEPTH];
   bit           fat_known [TABLE_DEPTH];
   int           known_list [$];
   int           undo_index [$];
   logic [27:0]  undo_value [$];
   int           work_left;
   bit           plan_ok;
   logic [16:0]  shadow_entry_count = 17'd0;
   logic [3:0]   shadow_shift = 4'd12;
   logic         shadow_mounted = 1'b0;

   fat_request_type requests_pending [$];
   fat_answer_type  answers_planned [$];
   fat_answer_type  answers_due [$];
   fat_request_type beat_out;
   fat_answer_type  beat_out_answer;
   bit           req_taken = 1'b0;
   bit           quiet = 1'b0;
   int           send_gap = 0;
   int           stall_run = 0;
   int           errors = 0;
   int           cycle_count = 0;
   int           results_checked = 0;
   int           settings_used = 1;
   int           op_count [4];
   int           status_seen [4];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int cluster_shift();
      if (shadow_shift < fcc_pkg::SHIFT_MIN) return fcc_pkg::SHIFT_MIN;
      if (shadow_shift > fcc_pkg::SHIFT_MAX) return fcc_pkg::SHIFT_MAX;
      return shadow_shift;
   endfunction

   // An entry may be looked at only once it has been loaded, and every item has a
   // work budget.
   function automatic bit peek_ok(int idx);
      if (!fat_known[idx] || work_left <= 0) plan_ok = 1'b0;
      work_left--;
      return plan_ok;
   endfunction

   function automatic void poke(int idx, logic [27:0] val);
      undo_index.push_back(idx);
      undo_value.push_back(fat_shadow[idx]);
      fat_shadow[idx] = val;
   endfunction

   function automatic int claim_free(int from);
      int limit;
      int i;
      limit = (shadow_entry_count < TABLE_DEPTH) ? int'(shadow_entry_count) : TABLE_DEPTH;
      for (i = from; i < limit; i++) begin
         if (!peek_ok(i)) return 0;
         if (fat_shadow[i] == 28'd0) begin
            poke(i, fcc_pkg::END_MARK);
            return i;
         end
      end
      return 0;
   endfunction

   function automatic fat_answer_type resolve_request(fat_request_type rq);
      fat_answer_type ans;
      int          shift;
      int          csize;
      int          steps;
      int          cur;
      int          nxt;
      int          hint;
      int          head;
      int          fresh;
      int          k;
      logic [31:0] chunk;
      ans = '{28'd0, 16'd0, 12'd0, 13'd0, fcc_pkg::STAT_OK};
      if (rq.op == fcc_pkg::OP_LOAD) begin
         poke(rq.entry_index, rq.entry_value);
         if (!fat_known[rq.entry_index]) begin
            fat_known[rq.entry_index] = 1'b1;
            known_list.push_back(rq.entry_index);
         end
         ans.value = rq.entry_value;
         return ans;
      end
      if (rq.op == fcc_pkg::OP_READ) begin
         if (peek_ok(rq.entry_index)) ans.value = fat_shadow[rq.entry_index];
         return ans;
      end
      if (!shadow_mounted) begin
         ans.status = fcc_pkg::STAT_UNMOUNTED;
         return ans;
      end
      if (rq.op == fcc_pkg::OP_ALLOC) begin
         ans.value = 28'(claim_free(2));
         ans.status = (ans.value == 28'd0) ? fcc_pkg::STAT_FULL : fcc_pkg::STAT_OK;
         return ans;
      end
      ans.first_cluster = rq.start_cluster;
      if (rq.bytes_left == 32'd0) return ans;
      shift = cluster_shift();
      csize = 1 << shift;
      hint = 2;
      head = rq.start_cluster;
      if (head < 2) begin
         head = claim_free(hint);
         if (head == 0) begin
            ans.first_cluster = 16'd0;
            ans.status = fcc_pkg::STAT_FULL;
            return ans;
         end
         hint = head + 1;
      end
      ans.first_cluster = 16'(head);
      steps = rq.byte_position >> shift;
      cur = head;
      for (k = 0; k < steps; k++) begin
         if (cur >= TABLE_DEPTH) begin
            ans.status = fcc_pkg::STAT_RANGE;
            return ans;
         end
         if (!peek_ok(cur)) return ans;
         nxt = fat_shadow[cur];
         if (nxt >= fcc_pkg::END_LOW) begin
            fresh = claim_free(hint);
            if (!plan_ok) return ans;
            if (fresh == 0) begin
               ans.status = fcc_pkg::STAT_FULL;
               return ans;
            end
            hint = fresh + 1;
            poke(cur, 28'(fresh));
            cur = fresh;
         end else begin
            cur = nxt;
         end
      end
      ans.value = 28'(cur);
      ans.offset = 12'(rq.byte_position & (csize - 1));
      chunk = csize - (rq.byte_position & (csize - 1));
      if (chunk > rq.bytes_left) chunk = rq.bytes_left;
      ans.chunk_length = 13'(chunk);
      return ans;
   endfunction

   // An item that would touch an unloaded entry or run too long is withdrawn and its
   // table changes are rolled back.
   function automatic bit plan_item(fat_request_type rq);
      fat_answer_type ans;
      undo_index.delete();
      undo_value.delete();
      work_left = WORK_BUDGET;
      plan_ok = 1'b1;
      ans = resolve_request(rq);
      if (plan_ok) begin
         requests_pending.push_back(rq);
         answers_planned.push_back(ans);
      end else begin
         while (undo_index.size() > 0)
            fat_shadow[undo_index.pop_back()] = undo_value.pop_back();
      end
      return plan_ok;
   endfunction

   function automatic void queue_one(fcc_pkg::op_type op, logic [15:0] idx, logic [27:0] val,
                                     logic [15:0] start, logic [31:0] pos, logic [31:0] left);
      fat_request_type rq;
      rq = '{op, idx, val, start, pos, left};
      void'(plan_item(rq));
   endfunction

   function automatic logic [27:0] random_link_value();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) return 28'd0;
      if (pick < 55) return fcc_pkg::END_LOW + 28'($urandom_range(0, 7));
      if (pick < 90) return 28'($urandom_range(2, PREFIX - 1));
      return 28'($urandom);
   endfunction

   function automatic fat_request_type random_request();
      fat_request_type rq;
      int           pick;
      int           csize;
      csize = 1 << cluster_shift();
      rq = '{fcc_pkg::OP_LOCATE, 16'($urandom), 28'($urandom), 16'($urandom),
             $urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
         rq.op = fcc_pkg::OP_LOAD;
         pick = $urandom_range(0, 99);
         if (pick < 70) rq.entry_index = 16'($urandom_range(0, PREFIX - 1));
         else if (pick >= 90) rq.entry_index = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0;
         rq.entry_value = random_link_value();
      end else if (pick < 36) begin
         rq.op = fcc_pkg::OP_READ;
         rq.entry_index = 16'(known_list[$urandom_range(0, known_list.size() - 1)]);
      end else if (pick < 52) begin
         rq.op = fcc_pkg::OP_ALLOC;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 15) rq.start_cluster = 16'($urandom_range(0, 1));
         else if (pick < 80) rq.start_cluster = 16'($urandom_range(2, PREFIX - 1));
         else if (pick < 90)
            rq.start_cluster = 16'(known_list[$urandom_range(0, known_list.size() - 1)]);
         pick = $urandom_range(0, 99);
         if (pick < 70) rq.byte_position = $urandom_range(0, 6 * csize - 1);
         else if (pick < 85)
            rq.byte_position = csize * $urandom_range(1, 5) - $urandom_range(0, 1);
         pick = $urandom_range(0, 99);
         if (pick < 8) rq.bytes_left = 32'd0;
         else if (pick < 48) rq.bytes_left = $urandom_range(1, csize);
         else if (pick < 63) rq.bytes_left = $urandom_range(1, 16);
         else if (pick >= 80) rq.bytes_left = 32'hFFFF_FFFF;
      end
      return rq;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (requests_pending.size() > 0) begin
               beat_out = requests_pending.pop_front();
               beat_out_answer = answers_planned.pop_front();
               req_op <= beat_out.op;
               req_entry_index <= beat_out.entry_index;
               req_entry_value <= beat_out.entry_value;
               req_start_cluster <= beat_out.start_cluster;
               req_byte_position <= beat_out.byte_position;
               req_bytes_left <= beat_out.bytes_left;
               req_valid <= 1'b1;
               if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (stall_run > 0) begin
            stall_run--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 7);
         end
      end
   end

   function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, label, want, got);
      end
   endfunction

   always @(posedge clock) begin
      fat_answer_type want;
      cycle_count++;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            answers_due.push_back(beat_out_answer);
            op_count[beat_out.op]++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               errors++;
               $display("%0t: result beat with none expected, expected nothing, got value 0x%0h",
                        $time, rsp_value);
            end else begin
               want = answers_due.pop_front();
               results_checked++;
               status_seen[want.status]++;
               check_field("value", want.value, rsp_value);
               check_field("first_cluster", want.first_cluster, rsp_first_cluster);
               check_field("offset", want.offset, rsp_offset);
               check_field("chunk_length", want.chunk_length, rsp_chunk_length);
               check_field("status", want.status, rsp_status);
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic drain();
      while (requests_pending.size() > 0 || req_valid || answers_due.size() > 0) begin
         @(posedge clock);
         #1;
      end
   endtask

   task automatic write_csr(logic [1:0] idx, logic [16:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         fcc_pkg::CSR_ENTRY_COUNT: shadow_entry_count = data;
         fcc_pkg::CSR_CLUSTER_LOG2: shadow_shift = data[3:0];
         fcc_pkg::CSR_MOUNTED: shadow_mounted = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(logic [16:0] count, logic [3:0] shift, logic mnt);
      drain();
      write_csr(fcc_pkg::CSR_ENTRY_COUNT, count);
      write_csr(fcc_pkg::CSR_CLUSTER_LOG2, 17'(shift));
      write_csr(fcc_pkg::CSR_MOUNTED, 17'(mnt));
      settings_used++;
   endtask

   task automatic run_phase(logic [16:0] count, logic [3:0] shift, logic mnt, int items);
      int n;
      int tries;
      bit placed;
      set_config(count, shift, mnt);
      for (n = 0; n < items; n++) begin
         placed = 1'b0;
         for (tries = 0; tries < 20 && !placed; tries++) placed = plan_item(random_request());
         if (!placed)
            queue_one(fcc_pkg::OP_READ,
                      16'(known_list[$urandom_range(0, known_list.size() - 1)]),
                      28'd0, 16'd0, 32'd0, 32'd0);
      end
   endtask

   initial begin
      int i;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      queue_one(fcc_pkg::OP_LOAD, 16'hFFFF, fcc_pkg::END_MARK, 16'd0, 32'd0, 32'd0);
      queue_one(fcc_pkg::OP_LOAD, 16'h0000, 28'd0, 16'd0, 32'd0, 32'd0);
      queue_one(fcc_pkg::OP_READ, 16'hFFFF, 28'd0, 16'd0, 32'd0, 32'd0);
      queue_one(fcc_pkg::OP_READ, 16'h0000, 28'd0, 16'd0, 32'd0, 32'd0);
      queue_one(fcc_pkg::OP_ALLOC, 16'd0, 28'd0, 16'd0, 32'd0, 32'd0);
      queue_one(fcc_pkg::OP_LOCATE, 16'd0, 28'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      set_config(17'd8, 4'd9, 1'b1);
      queue_one(fcc_pkg::OP_LOAD, 16'd1, 28'd0, 16'd0, 32'd0, 32'd0);
      queue_one(fcc_pkg::OP_LOAD, 16'd2, 28'd3, 16'd0, 32'd0, 32'd0);
      queue_one(fcc_pkg::OP_LOAD, 16'd3, fcc_pkg::END_MARK, 16'd0, 32'd0, 32'd0);
      queue_one(fcc_pkg::OP_LOAD, 16'd4, 28'd0, 16'd0, 32'd0, 32'd0);
      queue_one(fcc_pkg::OP_LOAD, 16'd5, 28'h0012345, 16'd0, 32'd0, 32'd0);
      queue_one(fcc_pkg::OP_LOAD, 16'd6, 28'd0, 16'd0, 32'd0, 32'd0);
      queue_one(fcc_pkg::OP_LOAD, 16'd7, fcc_pkg::END_LOW, 16'd0, 32'd0, 32'd0);
      queue_one(fcc_pkg::OP_ALLOC, 16'd0, 28'd0, 16'd0, 32'd0, 32'd0);
      queue_one(fcc_pkg::OP_LOCATE, 16'd0, 28'd0, 16'd2, 32'd1000, 32'd5000);
      // The chain ends at entry 3, so this beat extends it by one cluster.
      queue_one(fcc_pkg::OP_LOCATE, 16'd0, 28'd0, 16'd2, 32'd1024, 32'd3);
      queue_one(fcc_pkg::OP_LOCATE, 16'd0, 28'd0, 16'd0, 32'd511, 32'd1);
      queue_one(fcc_pkg::OP_LOCATE, 16'd0, 28'd0, 16'd5, 32'd1024, 32'd10);
      queue_one(fcc_pkg::OP_LOCATE, 16'd0, 28'd0, 16'd1, 32'hFFFF_FFFF, 32'd0);
      queue_one(fcc_pkg::OP_LOAD, 16'd5, 28'd0, 16'd0, 32'd0, 32'd0);
      queue_one(fcc_pkg::OP_LOCATE, 16'd0, 28'd0, 16'd5, 32'd1024, 32'd700);
      queue_one(fcc_pkg::OP_ALLOC, 16'd0, 28'd0, 16'd0, 32'd0, 32'd0);
      queue_one(fcc_pkg::OP_ALLOC, 16'd0, 28'd0, 16'd0, 32'd0, 32'd0);

      for (i = 0; i < PREFIX; i++)
         queue_one(fcc_pkg::OP_LOAD, 16'(i), random_link_value(), 16'd0, 32'd0, 32'd0);

      run_phase(17'd96, 4'd12, 1'b1, 150);
      run_phase(17'd40, 4'd9, 1'b1, 150);
      run_phase(17'd0, 4'd10, 1'b1, 60);
      run_phase(17'd96, 4'd0, 1'b1, 100);
      run_phase(17'h10000, 4'd15, 1'b1, 150);
      run_phase(17'd96, 4'd11, 1'b0, 60);
      run_phase(17'd2, 4'd9, 1'b1, 60);
      run_phase(17'hFFFF, 4'd12, 1'b1, 120);
      quiet = 1'b1;
      run_phase(17'd96, 4'd10, 1'b1, 200);

      drain();
      repeat (50) @(posedge clock);
      $display("Covered %0d request beats (%0d loads, %0d reads, %0d allocates, %0d locates) %s",
               op_count[0] + op_count[1] + op_count[2] + op_count[3],
               op_count[0], op_count[1], op_count[2], op_count[3],
               $sformatf("under %0d register settings.", settings_used));
      $display("Checked %0d result beats: %0d ok, %0d table full, %0d unmounted, %0d %s",
               results_checked, status_seen[0], status_seen[1], status_seen[2],
               status_seen[3], "off the table.");
      if (errors == 0 && answers_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
